[hdl/bhvm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhvm_pkg
// Shared types and codes for the byte-heap register VM execute stage:
// opcodes, status codes, register map and channel payload structs.
// ----------------------------------------------------------------------------
package bhvm_pkg;

  // Default sizes of the register file and the heap
  localparam int unsigned REG_COUNT_DEF  = 16;
  localparam int unsigned HEAP_DEPTH_DEF = 4096;

  // Configuration register widths and reset values
  localparam int unsigned HEAP_LIMIT_W  = 13;
  localparam int unsigned OP_ENABLE_W   = 7;
  localparam logic [HEAP_LIMIT_W-1:0] HEAP_LIMIT_RST = 13'd4096;
  localparam logic [OP_ENABLE_W-1:0]  OP_ENABLE_RST  = 7'h7F;

  // APB register map (byte address bit 2 selects the register)
  localparam int unsigned PADDR_W       = 3;
  localparam logic REG_HEAP_LIMIT       = 1'b0;
  localparam logic REG_OPCODE_ENABLE    = 1'b1;

  // Opcodes
  localparam logic [7:0] OP_HALT  = 8'd0;
  localparam logic [7:0] OP_LOAD  = 8'd1;
  localparam logic [7:0] OP_STORE = 8'd2;
  localparam logic [7:0] OP_MOVE  = 8'd3;
  localparam logic [7:0] OP_PUTI  = 8'd4;
  localparam logic [7:0] OP_ADD   = 8'd5;
  localparam logic [7:0] OP_SUB   = 8'd6;

  // Status codes
  localparam logic [2:0] ST_CONTINUE = 3'd0;
  localparam logic [2:0] ST_HALT     = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_SEGV     = 3'd3;
  localparam logic [2:0] ST_BADREG   = 3'd4;

  // Decoded instruction
  typedef struct packed {
    logic [7:0] req_type;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic [7:0] operand_c;
  } req_t;

  // Execution result
  typedef struct packed {
    logic [2:0]  status;
    logic        wrote_register;
    logic [3:0]  dest_register;
    logic [31:0] dest_value;
  } rsp_t;

endpackage

[hdl/byte_heap_register_vm_execute.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_heap_register_vm_execute
// Execute stage of a small register VM: 32-bit register file and byte heap,
// halt / load / store / move / puti / add / sub, one result per instruction.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  in        input      in_valid_i/in_stall_o   bhvm_pkg::req_t (opcode, a, b, c)
//  out       output     out_valid_o/out_stall_i bhvm_pkg::rsp_t (status, write report)
//  config    input      APB psel/penable/pwrite heap_limit @0x0, opcode_enable @0x4
//
//  One instruction per cycle when no output stall or heap clear holds it; results
//  pass register-file read, heap access and output register after transfer.
//  The registered register-file read and registered heap read set the depth;
//  register hazards are resolved by forwarding from the pending writes.
//  After reset the heap is cleared entry by entry with in_stall_o high.
//  An output stall backs up stage by stage; empty stages still take transfers.
//
module byte_heap_register_vm_execute #(
  parameter int unsigned REG_COUNT  = bhvm_pkg::REG_COUNT_DEF,
  parameter int unsigned HEAP_DEPTH = bhvm_pkg::HEAP_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // instruction channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bhvm_pkg::req_t                 in_data_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bhvm_pkg::rsp_t                 out_data_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bhvm_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned RAW = $clog2(REG_COUNT);
  localparam int unsigned HAW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [RAW-1:0] port_a_idx(input bhvm_pkg::req_t r);
    logic [7:0] sel;
    sel = (r.req_type == bhvm_pkg::OP_STORE) ? r.operand_a : r.operand_b;
    return sel[RAW-1:0];
  endfunction

  function automatic logic [RAW-1:0] port_b_idx(input bhvm_pkg::req_t r);
    logic [7:0] sel;
    sel = (r.req_type == bhvm_pkg::OP_STORE) ? r.operand_b : r.operand_c;
    return sel[RAW-1:0];
  endfunction

  function automatic logic reg_ok(input logic [7:0] idx);
    return {1'b0, idx} < 9'(REG_COUNT);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [bhvm_pkg::HEAP_LIMIT_W-1:0] heap_limit_q;
  logic [bhvm_pkg::OP_ENABLE_W-1:0]  op_enable_q;
  logic                              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  // Write on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_limit_q <= bhvm_pkg::HEAP_LIMIT_RST;
      op_enable_q  <= bhvm_pkg::OP_ENABLE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == bhvm_pkg::REG_HEAP_LIMIT) begin
        heap_limit_q <= pwdata[bhvm_pkg::HEAP_LIMIT_W-1:0];
      end else begin
        op_enable_q <= pwdata[bhvm_pkg::OP_ENABLE_W-1:0];
      end
    end
  end

  // Read back
  assign prdata = (paddr[2] == bhvm_pkg::REG_HEAP_LIMIT) ? 32'(heap_limit_q)
                                                         : 32'(op_enable_q);

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_go, s2_en, s1_en;
  logic s1_move, s2_move;
  logic in_xfer;
  logic heap_busy;

  assign out_go  = ~out_v_q | ~out_stall_i;
  assign s2_en   = ~s2_v_q | out_go;
  assign s1_en   = ~s1_v_q | s2_en;
  assign s2_move = s2_v_q & out_go;
  assign s1_move = s1_v_q & s2_en;

  assign in_stall_o = heap_busy | ~s1_en;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // --------------------------------------------------------------------------
  // Stage 1: register-file read returns, decode, ALU, heap address
  // --------------------------------------------------------------------------
  bhvm_pkg::req_t s1_q;
  logic [RAW-1:0] s1_ia, s1_ib;
  logic [RAW-1:0] rf_rd_a, rf_rd_b;
  logic [31:0]    rf_a_data, rf_b_data;
  logic [31:0]    fa, fb;

  // Stage 2 signals needed for forwarding
  bhvm_pkg::rsp_t s2_rsp_q;
  logic           s2_load_q;
  logic [HAW-1:0] s2_haddr_q;
  logic [RAW-1:0] s2_widx_q;
  logic [7:0]     heap_rd_data;
  logic [31:0]    s2_val;
  logic           s2_wr;

  // Last register write, registered at the edge that writes the register file
  logic           w3_v_q;
  logic [RAW-1:0] w3_idx_q;
  logic [31:0]    w3_data_q;

  // Capture the instruction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_en) begin
      s1_v_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_data_i;
    end
  end

  assign s1_ia = port_a_idx(s1_q);
  assign s1_ib = port_b_idx(s1_q);

  // Re-read the held instruction's registers while stage 1 stalls
  assign rf_rd_a = (s1_v_q & ~s2_en) ? s1_ia : port_a_idx(in_data_i);
  assign rf_rd_b = (s1_v_q & ~s2_en) ? s1_ib : port_b_idx(in_data_i);

  // Forward pending writes over the RAM data
  always_comb begin
    if (s2_v_q && s2_wr && s2_widx_q == s1_ia) begin
      fa = s2_val;
    end else if (w3_v_q && w3_idx_q == s1_ia) begin
      fa = w3_data_q;
    end else begin
      fa = rf_a_data;
    end
    if (s2_v_q && s2_wr && s2_widx_q == s1_ib) begin
      fb = s2_val;
    end else if (w3_v_q && w3_idx_q == s1_ib) begin
      fb = w3_data_q;
    end else begin
      fb = rf_b_data;
    end
  end

  logic           op_invalid;
  logic           ok_a, ok_b, ok_c;
  logic           addr_ok;
  logic [2:0]     s1_status;
  logic           s1_wr;
  logic [31:0]    s1_val;
  logic           s1_load;
  logic           s1_store;
  logic [HAW-1:0] s1_haddr;

  assign op_invalid = (s1_q.req_type > bhvm_pkg::OP_SUB) ||
                      !op_enable_q[s1_q.req_type[2:0]];
  assign ok_a       = reg_ok(s1_q.operand_a);
  assign ok_b       = reg_ok(s1_q.operand_b);
  assign ok_c       = reg_ok(s1_q.operand_c);
  assign addr_ok    = (fa < 32'(heap_limit_q)) && (fa < 32'(HEAP_DEPTH));
  assign s1_haddr   = fa[HAW-1:0];

  // Decode and execute
  always_comb begin
    s1_status = bhvm_pkg::ST_CONTINUE;
    s1_wr     = 1'b0;
    s1_val    = 32'd0;
    s1_load   = 1'b0;
    s1_store  = 1'b0;
    if (op_invalid) begin
      s1_status = bhvm_pkg::ST_INVALID;
    end else begin
      unique case (s1_q.req_type)
        bhvm_pkg::OP_HALT: begin
          s1_status = bhvm_pkg::ST_HALT;
        end
        bhvm_pkg::OP_PUTI: begin
          if (!ok_a) begin
            s1_status = bhvm_pkg::ST_BADREG;
          end else begin
            s1_wr  = 1'b1;
            s1_val = 32'(s1_q.operand_b);
          end
        end
        bhvm_pkg::OP_LOAD: begin
          if (!ok_a || !ok_b) begin
            s1_status = bhvm_pkg::ST_BADREG;
          end else if (!addr_ok) begin
            s1_status = bhvm_pkg::ST_SEGV;
          end else begin
            s1_wr   = 1'b1;
            s1_load = 1'b1;
          end
        end
        bhvm_pkg::OP_STORE: begin
          if (!ok_a || !ok_b) begin
            s1_status = bhvm_pkg::ST_BADREG;
          end else if (!addr_ok) begin
            s1_status = bhvm_pkg::ST_SEGV;
          end else begin
            s1_store = 1'b1;
          end
        end
        bhvm_pkg::OP_MOVE: begin
          if (!ok_a || !ok_b) begin
            s1_status = bhvm_pkg::ST_BADREG;
          end else begin
            s1_wr  = 1'b1;
            s1_val = fa;
          end
        end
        bhvm_pkg::OP_ADD: begin
          if (!ok_a || !ok_b || !ok_c) begin
            s1_status = bhvm_pkg::ST_BADREG;
          end else begin
            s1_wr  = 1'b1;
            s1_val = fa + fb;
          end
        end
        bhvm_pkg::OP_SUB: begin
          if (!ok_a || !ok_b || !ok_c) begin
            s1_status = bhvm_pkg::ST_BADREG;
          end else begin
            s1_wr  = 1'b1;
            s1_val = fa - fb;
          end
        end
        default: begin
          s1_status = bhvm_pkg::ST_INVALID;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: heap read returns, register write-back
  // --------------------------------------------------------------------------
  logic [HAW-1:0] heap_rd_addr;
  logic           heap_wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_en) begin
      s2_v_q <= s1_move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_rsp_q.status         <= s1_status;
      s2_rsp_q.wrote_register <= s1_wr;
      s2_rsp_q.dest_register  <= s1_wr ? s1_q.operand_a[3:0] : 4'd0;
      s2_rsp_q.dest_value     <= s1_val;
      s2_load_q               <= s1_load;
      s2_haddr_q              <= s1_haddr;
      s2_widx_q               <= s1_q.operand_a[RAW-1:0];
    end
  end

  // Hold the heap read address while stage 2 stalls
  assign heap_rd_addr = (s2_v_q & ~out_go) ? s2_haddr_q : s1_haddr;
  assign heap_wr_en   = s1_move & s1_store;

  assign s2_wr  = s2_rsp_q.wrote_register;
  assign s2_val = s2_load_q ? 32'(heap_rd_data) : s2_rsp_q.dest_value;

  // Remember the write done at this edge for the next forwarding check
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w3_v_q <= 1'b0;
    end else begin
      w3_v_q <= s2_move & s2_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      w3_idx_q  <= s2_widx_q;
      w3_data_q <= s2_val;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  bhvm_pkg::rsp_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_go) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      out_q.status         <= s2_rsp_q.status;
      out_q.wrote_register <= s2_rsp_q.wrote_register;
      out_q.dest_register  <= s2_rsp_q.dest_register;
      out_q.dest_value     <= s2_val;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Storage
  // --------------------------------------------------------------------------
  bhvm_rf #(
    .REG_COUNT (REG_COUNT)
  ) u_rf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_a_idx_i  (rf_rd_a),
    .rd_b_idx_i  (rf_rd_b),
    .rd_a_data_o (rf_a_data),
    .rd_b_data_o (rf_b_data),
    .wr_en_i     (s2_move & s2_wr),
    .wr_idx_i    (s2_widx_q),
    .wr_data_i   (s2_val)
  );

  bhvm_heap #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_heap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .busy_o    (heap_busy),
    .wr_en_i   (heap_wr_en),
    .wr_addr_i (s1_haddr),
    .wr_data_i (fb[7:0]),
    .rd_addr_i (heap_rd_addr),
    .rd_data_o (heap_rd_data)
  );

endmodule

[hdl/bhvm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhvm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read (old data on a same-address write).
// ----------------------------------------------------------------------------
module bhvm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

[hdl/bhvm_rf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhvm_rf
// Register file: two RAM copies for two read ports, one shared write port,
// and per-entry valid bits so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module bhvm_rf #(
  parameter int unsigned REG_COUNT = bhvm_pkg::REG_COUNT_DEF,
  localparam int unsigned RAW = $clog2(REG_COUNT)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [RAW-1:0] rd_a_idx_i,
  input  logic [RAW-1:0] rd_b_idx_i,
  output logic [31:0]    rd_a_data_o,
  output logic [31:0]    rd_b_data_o,
  input  logic           wr_en_i,
  input  logic [RAW-1:0] wr_idx_i,
  input  logic [31:0]    wr_data_i
);

  logic [REG_COUNT-1:0] vld_q;
  logic                 vld_a_q;
  logic                 vld_b_q;
  logic [31:0]          ram_a_data;
  logic [31:0]          ram_b_data;

  bhvm_ram #(
    .WIDTH (32),
    .DEPTH (REG_COUNT)
  ) u_ram_a (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en_i),
    .wr_addr_i (wr_idx_i),
    .wr_data_i (wr_data_i),
    .rd_addr_i (rd_a_idx_i),
    .rd_data_o (ram_a_data)
  );

  bhvm_ram #(
    .WIDTH (32),
    .DEPTH (REG_COUNT)
  ) u_ram_b (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en_i),
    .wr_addr_i (wr_idx_i),
    .wr_data_i (wr_data_i),
    .rd_addr_i (rd_b_idx_i),
    .rd_data_o (ram_b_data)
  );

  // Track written entries; sample valid bits alongside the RAM reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      vld_a_q <= (32'(rd_a_idx_i) < REG_COUNT) ? vld_q[rd_a_idx_i] : 1'b0;
      vld_b_q <= (32'(rd_b_idx_i) < REG_COUNT) ? vld_q[rd_b_idx_i] : 1'b0;
    end
  end

  // Mask never-written entries to zero
  assign rd_a_data_o = vld_a_q ? ram_a_data : 32'd0;
  assign rd_b_data_o = vld_b_q ? ram_b_data : 32'd0;

endmodule

[hdl/bhvm_heap.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhvm_heap
// Byte heap: one RAM plus a clearing sweep after reset that writes zero to
// every entry, one per cycle, while busy_o is high.
// ----------------------------------------------------------------------------
module bhvm_heap #(
  parameter int unsigned HEAP_DEPTH = bhvm_pkg::HEAP_DEPTH_DEF,
  localparam int unsigned HAW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  output logic           busy_o,
  input  logic           wr_en_i,
  input  logic [HAW-1:0] wr_addr_i,
  input  logic [7:0]     wr_data_i,
  input  logic [HAW-1:0] rd_addr_i,
  output logic [7:0]     rd_data_o
);

  localparam logic [HAW-1:0] LAST_ADDR = HAW'(HEAP_DEPTH - 1);

  logic           clr_busy_q;
  logic [HAW-1:0] clr_addr_q;
  logic           ram_wr_en;
  logic [HAW-1:0] ram_wr_addr;
  logic [7:0]     ram_wr_data;

  // Advance the clearing sweep until the last entry is written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + HAW'(1);
      if (clr_addr_q == LAST_ADDR) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Sweep owns the write port while busy
  assign ram_wr_en   = clr_busy_q | wr_en_i;
  assign ram_wr_addr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign ram_wr_data = clr_busy_q ? 8'd0 : wr_data_i;
  assign busy_o      = clr_busy_q;

  bhvm_ram #(
    .WIDTH (8),
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_addr_i (rd_addr_i),
    .rd_data_o (rd_data_o)
  );

endmodule

[verif/byte_heap_register_vm_execute_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_heap_register_vm_execute_tb
// Self-checking bench for the register VM execute stage. A cycle-free model
// of the register file, heap and configuration predicts one result per
// accepted instruction. Results are checked in order, field by field, while
// both channels idle and stall at random across several heap-limit and
// opcode-enable settings.
// ----------------------------------------------------------------------------
module byte_heap_register_vm_execute_tb;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct {
    bhvm_pkg::req_t req;
    int unsigned    gap;
  } instr_item_t;

  // Clock, reset and block ports
  logic                          clk_i     = 1'b0;
  logic                          rst_ni    = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  bhvm_pkg::req_t                in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  bhvm_pkg::rsp_t                out_data;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [bhvm_pkg::PADDR_W-1:0]  paddr     = '0;
  logic [31:0]                   pwdata    = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // Predicted machine state and configuration
  logic [31:0] vm_regs [bhvm_pkg::REG_COUNT_DEF]  = '{default: '0};
  logic [7:0]  vm_heap [bhvm_pkg::HEAP_DEPTH_DEF] = '{default: '0};
  logic [bhvm_pkg::HEAP_LIMIT_W-1:0] cfg_heap_limit = bhvm_pkg::HEAP_LIMIT_RST;
  logic [bhvm_pkg::OP_ENABLE_W-1:0]  cfg_op_enable  = bhvm_pkg::OP_ENABLE_RST;

  // Instructions waiting to be sent and results waiting to arrive
  instr_item_t    instr_queue [$];
  bhvm_pkg::rsp_t pending_results [$];

  int unsigned n_issued     = 0;
  int unsigned n_retired    = 0;
  int unsigned n_mismatch   = 0;
  int unsigned gap_cnt      = 0;
  int unsigned hold_cnt     = 0;
  int unsigned quiet_cycles = 0;
  bit          in_calm      = 1'b0;
  bit          out_calm     = 1'b0;

  byte_heap_register_vm_execute u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Execute one instruction on the model and return its result
  function automatic bhvm_pkg::rsp_t exec_predict(input bhvm_pkg::req_t ins);
    bhvm_pkg::rsp_t res;
    int unsigned    lim;
    logic [31:0]    addr;
    logic           a_ok, b_ok, c_ok;
    res  = '0;
    lim  = (cfg_heap_limit > bhvm_pkg::HEAP_DEPTH_DEF) ? bhvm_pkg::HEAP_DEPTH_DEF
                                                       : cfg_heap_limit;
    a_ok = ins.operand_a < bhvm_pkg::REG_COUNT_DEF;
    b_ok = ins.operand_b < bhvm_pkg::REG_COUNT_DEF;
    c_ok = ins.operand_c < bhvm_pkg::REG_COUNT_DEF;
    if (ins.req_type > bhvm_pkg::OP_SUB || !cfg_op_enable[ins.req_type[2:0]]) begin
      res.status = bhvm_pkg::ST_INVALID;
    end else if (ins.req_type == bhvm_pkg::OP_HALT) begin
      res.status = bhvm_pkg::ST_HALT;
    end else if (ins.req_type == bhvm_pkg::OP_PUTI) begin
      if (!a_ok) begin
        res.status = bhvm_pkg::ST_BADREG;
      end else begin
        res.wrote_register = 1'b1;
        res.dest_value     = {24'd0, ins.operand_b};
      end
    end else if (!a_ok || !b_ok ||
                 ((ins.req_type == bhvm_pkg::OP_ADD ||
                   ins.req_type == bhvm_pkg::OP_SUB) && !c_ok)) begin
      res.status = bhvm_pkg::ST_BADREG;
    end else begin
      case (ins.req_type)
        bhvm_pkg::OP_LOAD: begin
          addr = vm_regs[ins.operand_b[3:0]];
          if (addr >= lim) begin
            res.status = bhvm_pkg::ST_SEGV;
          end else begin
            res.wrote_register = 1'b1;
            res.dest_value     = {24'd0, vm_heap[addr[11:0]]};
          end
        end
        bhvm_pkg::OP_STORE: begin
          addr = vm_regs[ins.operand_a[3:0]];
          if (addr >= lim) begin
            res.status = bhvm_pkg::ST_SEGV;
          end else begin
            vm_heap[addr[11:0]] = vm_regs[ins.operand_b[3:0]][7:0];
          end
        end
        bhvm_pkg::OP_MOVE: begin
          res.wrote_register = 1'b1;
          res.dest_value     = vm_regs[ins.operand_b[3:0]];
        end
        bhvm_pkg::OP_ADD: begin
          res.wrote_register = 1'b1;
          res.dest_value     = vm_regs[ins.operand_b[3:0]] + vm_regs[ins.operand_c[3:0]];
        end
        default: begin
          // subtract, wrapping at 32 bits
          res.wrote_register = 1'b1;
          res.dest_value     = vm_regs[ins.operand_b[3:0]] - vm_regs[ins.operand_c[3:0]];
        end
      endcase
    end
    if (res.wrote_register) begin
      res.dest_register = ins.operand_a[3:0];
      vm_regs[ins.operand_a[3:0]] = res.dest_value;
    end
    return res;
  endfunction

  // Queue one instruction with its idle gap
  task automatic push_instr(input logic [7:0] op, a, b, c);
    instr_item_t it;
    if (n_issued % 40 == 0) in_calm = ($urandom_range(0, 3) == 0);
    it.req = {op, a, b, c};
    it.gap = in_calm ? 0 : $urandom_range(0, 8);
    instr_queue.push_back(it);
    n_issued++;
  endtask

  // Register index: mostly in range, sometimes out of range
  function automatic logic [7:0] pick_reg();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(16, 255));
    return 8'($urandom_range(0, 15));
  endfunction

  // Emit one random step: noise, a heap access sequence or a single operation
  task automatic gen_step();
    logic [7:0]  ra, rb, hi, lo, op;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      push_instr(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 45) begin
      // build an address in ra, then load and store through it
      ra = 8'($urandom_range(0, 15));
      rb = 8'((ra + $urandom_range(1, 15)) % 16);
      case ($urandom_range(0, 3))
        0: lo = 8'hFF;
        1: lo = 8'h00;
        default: lo = 8'($urandom);
      endcase
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0: hi = 8'd16;
          1: hi = 8'd15;
          default: hi = 8'($urandom_range(0, 16));
        endcase
        push_instr(bhvm_pkg::OP_PUTI, ra, hi, 8'($urandom));
        repeat (8) push_instr(bhvm_pkg::OP_ADD, ra, ra, ra);
        push_instr(bhvm_pkg::OP_PUTI, rb, lo, 8'($urandom));
        push_instr(bhvm_pkg::OP_ADD, ra, ra, rb);
      end else begin
        push_instr(bhvm_pkg::OP_PUTI, ra, lo, 8'($urandom));
      end
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1)) begin
          push_instr(bhvm_pkg::OP_STORE, ra, 8'($urandom_range(0, 15)), 8'($urandom));
        end else begin
          push_instr(bhvm_pkg::OP_LOAD, 8'((ra + $urandom_range(1, 15)) % 16), ra,
                     8'($urandom));
        end
      end
    end else begin
      op = ($urandom_range(0, 19) == 0) ? bhvm_pkg::OP_HALT : 8'($urandom_range(1, 6));
      push_instr(op, pick_reg(), (op == bhvm_pkg::OP_PUTI) ? 8'($urandom) : pick_reg(),
                 pick_reg());
    end
  endtask

  // Wait until every result is in, then let the pipeline settle
  task automatic wait_drained();
    while (n_retired != n_issued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_cfg(input logic sel, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == bhvm_pkg::REG_HEAP_LIMIT) cfg_heap_limit = value[bhvm_pkg::HEAP_LIMIT_W-1:0];
    else cfg_op_enable = value[bhvm_pkg::OP_ENABLE_W-1:0];
  endtask

  // Optionally reconfigure while idle, then queue at least n random instructions
  task automatic run_phase(input bit set_cfg,
                           input logic [bhvm_pkg::HEAP_LIMIT_W-1:0] lim,
                           input logic [bhvm_pkg::OP_ENABLE_W-1:0] en,
                           input int unsigned n);
    int unsigned stop;
    if (set_cfg) begin
      wait_drained();
      write_cfg(bhvm_pkg::REG_HEAP_LIMIT, {19'($urandom), lim});
      write_cfg(bhvm_pkg::REG_OPCODE_ENABLE, {25'($urandom), en});
    end
    stop = n_issued + n;
    while (n_issued < stop) gen_step();
  endtask

  // Stimulus: reset, directed cases, then random phases
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_instr(bhvm_pkg::OP_PUTI, 8'd0, 8'd0, 8'hFF);
    push_instr(bhvm_pkg::OP_PUTI, 8'd15, 8'hFF, 8'h00);
    push_instr(bhvm_pkg::OP_PUTI, 8'd1, 8'h80, 8'h5A);
    push_instr(bhvm_pkg::OP_HALT, 8'hFF, 8'hFF, 8'hFF);
    push_instr(bhvm_pkg::OP_LOAD, 8'd2, 8'd0, 8'hFF);
    push_instr(bhvm_pkg::OP_STORE, 8'd1, 8'd15, 8'hFF);
    push_instr(bhvm_pkg::OP_LOAD, 8'd3, 8'd1, 8'h00);
    push_instr(bhvm_pkg::OP_MOVE, 8'd4, 8'd15, 8'hFF);
    // wrap below zero and past 2^32
    push_instr(bhvm_pkg::OP_SUB, 8'd5, 8'd0, 8'd15);
    push_instr(bhvm_pkg::OP_ADD, 8'd6, 8'd5, 8'd5);
    push_instr(bhvm_pkg::OP_SUB, 8'd7, 8'd15, 8'd15);
    push_instr(bhvm_pkg::OP_ADD, 8'd8, 8'd15, 8'd1);
    // huge addresses fault
    push_instr(bhvm_pkg::OP_LOAD, 8'd9, 8'd5, 8'd0);
    push_instr(bhvm_pkg::OP_STORE, 8'd5, 8'd15, 8'd0);
    // unknown opcodes
    push_instr(8'd7, 8'd0, 8'd0, 8'd0);
    push_instr(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // register index out of range, in every operand position
    push_instr(bhvm_pkg::OP_PUTI, 8'd16, 8'd1, 8'd0);
    push_instr(bhvm_pkg::OP_MOVE, 8'd1, 8'hFF, 8'd0);
    push_instr(bhvm_pkg::OP_ADD, 8'd1, 8'd1, 8'd16);
    push_instr(bhvm_pkg::OP_STORE, 8'd200, 8'd1, 8'd0);
    push_instr(bhvm_pkg::OP_LOAD, 8'd3, 8'd16, 8'd0);
    push_instr(bhvm_pkg::OP_SUB, 8'hFF, 8'd0, 8'd0);

    run_phase(1'b0, '0, '0, 240);
    run_phase(1'b1, 13'd0, 7'h7F, 240);
    run_phase(1'b1, 13'd8191, 7'h7F, 240);
    run_phase(1'b1, 13'd4096, 7'h00, 60);
    run_phase(1'b1, 13'd1, 7'($urandom), 240);
    run_phase(1'b1, 13'($urandom_range(1, 4096)), 7'($urandom), 240);
    run_phase(1'b1, 13'd4095, 7'h7F, 240);
    run_phase(1'b1, 13'($urandom), 7'($urandom), 240);
    run_phase(1'b1, 13'd4096, 7'h7F, 200);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Driver: hold a stalled transfer, else wait out the gap and send the next
  always @(posedge clk_i) begin : drive_instr
    instr_item_t nxt;
    logic        took;
    if (rst_ni) begin
      took = in_valid && !in_stall;
      if (took) pending_results.push_back(exec_predict(in_data));
      if (in_valid && !took) begin
        // hold payload and valid
      end else if (instr_queue.size() != 0 && gap_cnt >= instr_queue[0].gap) begin
        nxt = instr_queue.pop_front();
        in_data  <= nxt.req;
        in_valid <= 1'b1;
        gap_cnt  = 0;
      end else begin
        in_valid <= 1'b0;
        if (instr_queue.size() != 0) gap_cnt++;
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction
  always @(posedge clk_i) begin : check_result
    bhvm_pkg::rsp_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("unexpected result: st=%0d wr=%0b rd=%0d val=%08h",
                     out_data.status, out_data.wrote_register,
                     out_data.dest_register, out_data.dest_value);
          end
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status ||
              out_data.wrote_register !== want.wrote_register ||
              out_data.dest_register !== want.dest_register ||
              out_data.dest_value !== want.dest_value) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("mismatch on result %0d: expected st=%0d wr=%0b rd=%0d val=%08h",
                       n_retired, want.status, want.wrote_register,
                       want.dest_register, want.dest_value);
              $display("  got st=%0d wr=%0b rd=%0d val=%08h",
                       out_data.status, out_data.wrote_register,
                       out_data.dest_register, out_data.dest_value);
            end
          end
        end
        n_retired++;
        if (n_retired % 50 == 0) out_calm = ($urandom_range(0, 3) == 0);
        hold_cnt = out_calm ? 0 : $urandom_range(0, 8);
      end
      // stall until the drawn hold count runs out
      if (hold_cnt != 0) begin
        out_stall <= 1'b1;
        hold_cnt--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

endmodule

[files.f]
hdl/bhvm_pkg.sv
hdl/bhvm_ram.sv
hdl/bhvm_rf.sv
hdl/bhvm_heap.sv
hdl/byte_heap_register_vm_execute.sv
verif/byte_heap_register_vm_execute_tb.sv
